// File: rtl/prd_pkg.sv
// Shared types and constants for the pinhole ray direction block.
`timescale 1ns / 1ps
package prd_pkg;

  localparam int unsigned CFG_W  = 48;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned VP_W   = 13;
  localparam int unsigned TAN_W  = 24;
  localparam int unsigned RT_W   = 46;
  localparam int unsigned GH_W   = 51;
  localparam int unsigned MAG_W  = 31;
  localparam int unsigned DIR_W  = 16;

  localparam logic [TAN_W-1:0] TAN_RST = 24'd65536;
  localparam logic [VP_W-1:0]  VW_RST  = 13'd1920;
  localparam logic [VP_W-1:0]  VH_RST  = 13'd1080;

  typedef enum logic [IDX_W-1:0] {
    REG_FWD = 3'd0,
    REG_UP  = 3'd1,
    REG_TAN = 3'd2,
    REG_VW  = 3'd3,
    REG_VH  = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_START,
    BS_SQ,
    BS_SQRT,
    BS_DIV,
    BS_NEXT,
    BS_CROSS,
    BS_FIN
  } bstate_e;

  typedef struct packed {
    logic [2:0][RT_W-1:0] rt;
    logic [2:0][RT_W-1:0] wt;
    logic [2:0][GH_W-1:0] gh;
    logic [VP_W-1:0]      vw;
    logic [VP_W-1:0]      vh;
  } coef_t;

  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } item_t;

endpackage

// File: rtl/prd_pix_if.sv
// Pixel coordinate channel.
`timescale 1ns / 1ps
interface prd_pix_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// File: rtl/prd_dir_if.sv
// Ray direction channel.
`timescale 1ns / 1ps
interface prd_dir_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

// File: rtl/prd_basis.sv
// Config registers and sequencer that builds the camera basis coefficients.
`timescale 1ns / 1ps
module prd_basis (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [prd_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [prd_pkg::CFG_W-1:0]    cfg_data_i,
  output prd_pkg::coef_t               coef_o,
  output logic                         busy_o
);

  function automatic logic signed [67:0] rnd_shr(input logic signed [67:0] a, input int k);
    logic [67:0] m;
    m = a[67] ? 68'(-a) : 68'(a);
    m = (m + (68'd1 << (k - 1))) >> k;
    return a[67] ? $signed(68'(-m)) : $signed(m);
  endfunction

  function automatic logic [33:0] mag34(input logic [33:0] v);
    return v[33] ? 34'(-$signed(v)) : v;
  endfunction

  logic [47:0]             fwd_q, up_q;
  logic [prd_pkg::TAN_W-1:0] tan_q;
  logic [prd_pkg::VP_W-1:0]  vw_q, vh_q;

  prd_pkg::bstate_e state_q, state_d;
  logic [1:0]  phase_q, phase_d;
  logic        cph_q, cph_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [1:0]  ci_q, ci_d;
  logic [2:0][33:0] vin_q, vin_d;
  logic [2:0][31:0] vout_q, vout_d;
  logic [2:0][31:0] g_q, g_d, un_q, un_d, r_q, r_d, w_q, w_d;
  logic [63:0] acc_q, acc_d, res_q, res_d, num_q, num_d;
  logic [30:0] quo_q, quo_d;
  logic signed [67:0] tmp_q, tmp_d;
  logic [2:0][prd_pkg::RT_W-1:0] rt_q, rt_d, wt_q, wt_d;
  logic [2:0][prd_pkg::GH_W-1:0] gh_q, gh_d;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;
  logic [63:0] bitv, trial, dv;
  logic [4:0]  qi;
  logic [30:0] qn;
  logic signed [67:0] cr;
  logic [1:0]  ai, bi, fg, fj;
  logic [2:0][31:0] opa, opb;
  logic [2:0][21:0] r20, w20, g20;

  assign prod = mul_a * mul_b;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r20[i] = 22'(rnd_shr(68'($signed(r_q[i])), 10));
      w20[i] = 22'(rnd_shr(68'($signed(w_q[i])), 10));
      g20[i] = 22'(rnd_shr(68'($signed(g_q[i])), 10));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= '0;
      up_q  <= '0;
      tan_q <= prd_pkg::TAN_RST;
      vw_q  <= prd_pkg::VW_RST;
      vh_q  <= prd_pkg::VH_RST;
    end else if (cfg_we_i) begin
      case (prd_pkg::reg_idx_e'(cfg_idx_i))
        prd_pkg::REG_FWD: fwd_q <= cfg_data_i;
        prd_pkg::REG_UP:  up_q  <= cfg_data_i;
        prd_pkg::REG_TAN: tan_q <= cfg_data_i[prd_pkg::TAN_W-1:0];
        prd_pkg::REG_VW:  vw_q  <= cfg_data_i[prd_pkg::VP_W-1:0];
        prd_pkg::REG_VH:  vh_q  <= cfg_data_i[prd_pkg::VP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prd_pkg::BS_IDLE;
      phase_q <= '0;
      cph_q   <= 1'b0;
      cnt_q   <= '0;
      ci_q    <= '0;
      rt_q    <= '0;
      wt_q    <= '0;
      gh_q    <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cph_q   <= cph_d;
      cnt_q   <= cnt_d;
      ci_q    <= ci_d;
      rt_q    <= rt_d;
      wt_q    <= wt_d;
      gh_q    <= gh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vin_q  <= vin_d;
    vout_q <= vout_d;
    g_q    <= g_d;
    un_q   <= un_d;
    r_q    <= r_d;
    w_q    <= w_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
    num_q  <= num_d;
    quo_q  <= quo_d;
    tmp_q  <= tmp_d;
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cph_d   = cph_q;
    cnt_d   = cnt_q;
    ci_d    = ci_q;
    vin_d   = vin_q;
    vout_d  = vout_q;
    g_d     = g_q;
    un_d    = un_q;
    r_d     = r_q;
    w_d     = w_q;
    acc_d   = acc_q;
    res_d   = res_q;
    num_d   = num_q;
    quo_d   = quo_q;
    tmp_d   = tmp_q;
    rt_d    = rt_q;
    wt_d    = wt_q;
    gh_d    = gh_q;
    mul_a   = '0;
    mul_b   = '0;
    bitv    = 64'h4000_0000_0000_0000 >> {cnt_q, 1'b0};
    trial   = res_q + bitv;
    qi      = 5'd31 - cnt_q;
    dv      = 64'(res_q[31:0]) << qi;
    qn      = quo_q;
    cr      = '0;
    opa     = cph_q ? r_q : g_q;
    opb     = cph_q ? g_q : un_q;
    ai      = 2'd0;
    bi      = 2'd0;
    fg      = (cnt_q >= 5'd6) ? 2'd2 : ((cnt_q >= 5'd3) ? 2'd1 : 2'd0);
    fj      = 2'(cnt_q - 5'(fg) * 5'd3);

    case (state_q)
      prd_pkg::BS_IDLE: ;
      prd_pkg::BS_START: begin
        for (int i = 0; i < 3; i++) vin_d[i] = 34'($signed(fwd_q[16*i +: 16]));
        acc_d   = '0;
        cnt_d   = '0;
        phase_d = 2'd0;
        state_d = prd_pkg::BS_SQ;
      end
      prd_pkg::BS_SQ: begin
        mul_a = $signed(mag34(vin_q[cnt_q[1:0]]));
        mul_b = $signed(mag34(vin_q[cnt_q[1:0]]));
        acc_d = acc_q + prod[63:0];
        if (cnt_q == 5'd2) begin
          cnt_d   = '0;
          res_d   = '0;
          state_d = prd_pkg::BS_SQRT;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      prd_pkg::BS_SQRT: begin
        if (acc_q >= trial) begin
          acc_d = acc_q - trial;
          res_d = (res_q >> 1) + bitv;
        end else begin
          res_d = res_q >> 1;
        end
        if (cnt_q == 5'd31) begin
          cnt_d   = '0;
          ci_d    = '0;
          state_d = prd_pkg::BS_DIV;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      prd_pkg::BS_DIV: begin
        if (cnt_q == 5'd0) begin
          num_d = (64'(mag34(vin_q[ci_q])) << 30) + 64'(res_q[31:1]);
          quo_d = '0;
          cnt_d = 5'd1;
        end else begin
          if (num_q >= dv) begin
            num_d = num_q - dv;
            qn[qi] = 1'b1;
          end
          quo_d = qn;
          if (cnt_q == 5'd31) begin
            if (res_q[31:0] == 32'd0) begin
              vout_d[ci_q] = '0;
            end else if (vin_q[ci_q][33]) begin
              vout_d[ci_q] = 32'(-$signed({1'b0, qn}));
            end else begin
              vout_d[ci_q] = 32'(qn);
            end
            cnt_d = '0;
            if (ci_q == 2'd2) begin
              state_d = prd_pkg::BS_NEXT;
            end else begin
              ci_d = ci_q + 2'd1;
            end
          end else begin
            cnt_d = cnt_q + 5'd1;
          end
        end
      end
      prd_pkg::BS_NEXT: begin
        cnt_d = '0;
        case (phase_q)
          2'd0: begin
            g_d = vout_q;
            for (int i = 0; i < 3; i++) vin_d[i] = 34'($signed(up_q[16*i +: 16]));
            acc_d   = '0;
            phase_d = 2'd1;
            state_d = prd_pkg::BS_SQ;
          end
          2'd1: begin
            un_d    = vout_q;
            cph_d   = 1'b0;
            state_d = prd_pkg::BS_CROSS;
          end
          default: begin
            r_d     = vout_q;
            cph_d   = 1'b1;
            state_d = prd_pkg::BS_CROSS;
          end
        endcase
      end
      prd_pkg::BS_CROSS: begin
        case (cnt_q)
          5'd0: begin ai = 2'd1; bi = 2'd2; end
          5'd1: begin ai = 2'd2; bi = 2'd1; end
          5'd2: begin ai = 2'd2; bi = 2'd0; end
          5'd3: begin ai = 2'd0; bi = 2'd2; end
          5'd4: begin ai = 2'd0; bi = 2'd1; end
          default: begin ai = 2'd1; bi = 2'd0; end
        endcase
        mul_a = 34'($signed(opa[ai]));
        mul_b = 34'($signed(opb[bi]));
        if (!cnt_q[0]) begin
          tmp_d = prod;
        end else begin
          cr = rnd_shr(tmp_q - prod, 30);
          if (!cph_q) vin_d[cnt_q[2:1]] = cr[33:0];
          else        w_d[cnt_q[2:1]]   = cr[31:0];
        end
        if (cnt_q == 5'd5) begin
          cnt_d = '0;
          if (!cph_q) begin
            acc_d   = '0;
            phase_d = 2'd2;
            state_d = prd_pkg::BS_SQ;
          end else begin
            state_d = prd_pkg::BS_FIN;
          end
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      prd_pkg::BS_FIN: begin
        case (fg)
          2'd0: begin
            mul_a = 34'($signed(r20[fj]));
            mul_b = $signed({10'd0, tan_q});
            rt_d[fj] = prod[prd_pkg::RT_W-1:0];
          end
          2'd1: begin
            mul_a = 34'($signed(w20[fj]));
            mul_b = $signed({10'd0, tan_q});
            wt_d[fj] = prod[prd_pkg::RT_W-1:0];
          end
          default: begin
            mul_a = 34'($signed(g20[fj]));
            mul_b = $signed({21'd0, vh_q});
            gh_d[fj] = {prod[34:0], 16'd0};
          end
        endcase
        if (cnt_q == 5'd8) begin
          cnt_d   = '0;
          state_d = prd_pkg::BS_IDLE;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      default: state_d = prd_pkg::BS_IDLE;
    endcase

    if (cfg_we_i) state_d = prd_pkg::BS_START;
  end

  assign busy_o    = (state_q != prd_pkg::BS_IDLE) || cfg_we_i;
  assign coef_o.rt = rt_q;
  assign coef_o.wt = wt_q;
  assign coef_o.gh = gh_q;
  assign coef_o.vw = vw_q;
  assign coef_o.vh = vh_q;

endmodule

// File: rtl/prd_front.sv
// Front pipeline: pixel offsets, weighted basis sum and range reduction.
`timescale 1ns / 1ps
module prd_front #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [COORD_BITS-1:0] pixel_x_i,
  input  logic [COORD_BITS-1:0] pixel_y_i,
  input  prd_pkg::coef_t        coef_i,
  output logic                  valid_o,
  output prd_pkg::item_t        item_o
);

  localparam int unsigned EXW = ((COORD_BITS + 1 > prd_pkg::VP_W) ? COORD_BITS + 1
                                                                    : prd_pkg::VP_W) + 1;
  localparam int unsigned PW  = prd_pkg::RT_W + EXW;
  localparam int unsigned DW  = PW + 2;
  localparam int unsigned NSH = $clog2(DW);

  logic               va_q, vb_q, vc_q, ve_q;
  logic signed [EXW-1:0] ex_q, ey_q;
  logic [2:0][PW-1:0] px_q, py_q;
  logic [2:0][DW-1:0] d_q;
  logic [2:0][DW-1:0] sm_q [NSH+1];
  logic [2:0]         rb_q [NSH+1];
  logic [2:0]         ng_q [NSH+1];
  logic               vs_q [NSH+1];
  logic [2:0][prd_pkg::MAG_W-1:0] mag_q;
  logic [2:0]         neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      ve_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      ve_q <= vs_q[NSH];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ex_q <= $signed(EXW'({pixel_x_i, 1'b1})) - $signed(EXW'(coef_i.vw));
      ey_q <= $signed(EXW'({pixel_y_i, 1'b1})) - $signed(EXW'(coef_i.vh));
      for (int i = 0; i < 3; i++) begin
        px_q[i] <= PW'($signed(coef_i.rt[i]) * ex_q);
        py_q[i] <= PW'($signed(coef_i.wt[i]) * ey_q);
        d_q[i]  <= DW'($signed(px_q[i])) + DW'($signed(py_q[i]))
                 + DW'($signed(coef_i.gh[i]));
      end
    end
  end

  // sign and magnitude, round bit starts clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q[0] <= 1'b0;
    end else if (en_i) begin
      vs_q[0] <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        ng_q[0][i] <= d_q[i][DW-1];
        sm_q[0][i] <= d_q[i][DW-1] ? DW'(-$signed(d_q[i])) : d_q[i];
        rb_q[0][i] <= 1'b0;
      end
    end
  end

  // binary search on the shift that brings the largest magnitude below 2^30
  for (genvar s = 0; s < NSH; s++) begin : g_shift
    localparam int unsigned K = 1 << (NSH - 1 - s);
    logic big;

    assign big = ((sm_q[s][0] >> (29 + K)) != '0) || ((sm_q[s][1] >> (29 + K)) != '0)
              || ((sm_q[s][2] >> (29 + K)) != '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vs_q[s+1] <= vs_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ng_q[s+1] <= ng_q[s];
        for (int i = 0; i < 3; i++) begin
          if (big) begin
            sm_q[s+1][i] <= sm_q[s][i] >> K;
            rb_q[s+1][i] <= sm_q[s][i][K-1];
          end else begin
            sm_q[s+1][i] <= sm_q[s][i];
            rb_q[s+1][i] <= rb_q[s][i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= ng_q[NSH];
      for (int i = 0; i < 3; i++) begin
        mag_q[i] <= sm_q[NSH][i][prd_pkg::MAG_W-1:0] + prd_pkg::MAG_W'(rb_q[NSH][i]);
      end
    end
  end

  assign valid_o    = ve_q;
  assign item_o.neg = neg_q;
  assign item_o.mag = mag_q;

endmodule

// File: rtl/prd_norm.sv
// Normalising pipeline: sum of squares, root, per-component divide, saturation.
`timescale 1ns / 1ps
module prd_norm #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  prd_pkg::item_t              item_i,
  output logic                        valid_o,
  output logic [2:0][prd_pkg::DIR_W-1:0] dir_o
);

  localparam int unsigned MW = prd_pkg::MAG_W;
  localparam int unsigned NW = FRAC_BITS + 33;
  localparam int unsigned QW = FRAC_BITS + 1;
  localparam int unsigned SQ_STEPS = 32;

  logic                vq_q;
  logic [2:0][61:0]    sq_q;
  logic [2:0][MW-1:0]  mq_q;
  logic [2:0]          nq_q;

  logic [63:0]         rem_q [SQ_STEPS+1];
  logic [63:0]         res_q [SQ_STEPS+1];
  logic [2:0][MW-1:0]  mr_q  [SQ_STEPS+1];
  logic [2:0]          nr_q  [SQ_STEPS+1];
  logic                vr_q  [SQ_STEPS+1];

  logic [2:0][NW-1:0]  num_q [QW+1];
  logic [2:0][QW-1:0]  quo_q [QW+1];
  logic [31:0]         nd_q  [QW+1];
  logic [2:0]          ngd_q [QW+1];
  logic                z_q   [QW+1];
  logic                vd_q  [QW+1];

  logic                vo_q;
  logic [2:0][prd_pkg::DIR_W-1:0] dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq_q     <= 1'b0;
      vr_q[0]  <= 1'b0;
      vd_q[0]  <= 1'b0;
      vo_q     <= 1'b0;
    end else if (en_i) begin
      vq_q     <= valid_i;
      vr_q[0]  <= vq_q;
      vd_q[0]  <= vr_q[SQ_STEPS];
      vo_q     <= vd_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) sq_q[i] <= item_i.mag[i] * item_i.mag[i];
      mq_q       <= item_i.mag;
      nq_q       <= item_i.neg;
      rem_q[0]   <= 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
      res_q[0]   <= '0;
      mr_q[0]    <= mq_q;
      nr_q[0]    <= nq_q;
    end
  end

  // integer square root, one result bit per stage
  for (genvar t = 0; t < SQ_STEPS; t++) begin : g_sqrt
    localparam logic [63:0] BV = 64'd1 << (62 - 2 * t);
    logic [63:0] trial;

    assign trial = res_q[t] + BV;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vr_q[t+1] <= 1'b0;
      end else if (en_i) begin
        vr_q[t+1] <= vr_q[t];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mr_q[t+1] <= mr_q[t];
        nr_q[t+1] <= nr_q[t];
        if (rem_q[t] >= trial) begin
          rem_q[t+1] <= rem_q[t] - trial;
          res_q[t+1] <= (res_q[t] >> 1) + BV;
        end else begin
          rem_q[t+1] <= rem_q[t];
          res_q[t+1] <= res_q[t] >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nd_q[0]  <= res_q[SQ_STEPS][31:0];
      z_q[0]   <= (res_q[SQ_STEPS][31:0] == 32'd0);
      ngd_q[0] <= nr_q[SQ_STEPS];
      quo_q[0] <= '0;
      for (int i = 0; i < 3; i++) begin
        num_q[0][i] <= (NW'(mr_q[SQ_STEPS][i]) << FRAC_BITS)
                     + NW'(res_q[SQ_STEPS][31:1]);
      end
    end
  end

  // restoring divide, quotient bits from the top down
  for (genvar d = 0; d < QW; d++) begin : g_div
    localparam int unsigned B = QW - 1 - d;
    logic [NW-1:0] dv;

    assign dv = NW'(nd_q[d]) << B;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[d+1] <= 1'b0;
      end else if (en_i) begin
        vd_q[d+1] <= vd_q[d];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nd_q[d+1]  <= nd_q[d];
        z_q[d+1]   <= z_q[d];
        ngd_q[d+1] <= ngd_q[d];
        for (int i = 0; i < 3; i++) begin
          if (num_q[d][i] >= dv) begin
            num_q[d+1][i]    <= num_q[d][i] - dv;
            quo_q[d+1][i]    <= quo_q[d][i] | (QW'(1) << B);
          end else begin
            num_q[d+1][i]    <= num_q[d][i];
            quo_q[d+1][i]    <= quo_q[d][i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (z_q[QW]) begin
          dir_q[i] <= '0;
        end else if (ngd_q[QW][i]) begin
          if (32'(quo_q[QW][i]) > 32'd32768) dir_q[i] <= 16'h8000;
          else                                dir_q[i] <= 16'(-32'(quo_q[QW][i]));
        end else begin
          if (32'(quo_q[QW][i]) > 32'd32767) dir_q[i] <= 16'h7FFF;
          else                                dir_q[i] <= 16'(quo_q[QW][i]);
        end
      end
    end
  end

  assign valid_o = vo_q;
  assign dir_o   = dir_q;

endmodule

// File: rtl/pinhole_ray_direction.sv
// Top level: pinhole camera primary ray direction generator.
// Throughput: one item per cycle; the whole pipeline stalls together on output back-pressure.
// A config write starts a basis rebuild in a shared-multiplier sequencer;
// no item is accepted until it completes.
// Reset clears the valid bits and loads the register defaults; the output valid is then low.
`timescale 1ns / 1ps
module pinhole_ray_direction #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 14
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [prd_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [prd_pkg::CFG_W-1:0] cfg_data_i,
  prd_pix_if.sink                   pix_i,
  prd_dir_if.source                 dir_o
);

  prd_pkg::coef_t coef;
  prd_pkg::item_t item;
  logic           busy;
  logic           en;
  logic           fr_valid;
  logic           out_valid;
  logic [2:0][prd_pkg::DIR_W-1:0] dir;

  assign en          = !out_valid || dir_o.ready;
  assign pix_i.ready = en && !busy;

  prd_basis u_basis (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .coef_o     (coef),
    .busy_o     (busy)
  );

  prd_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (pix_i.valid && pix_i.ready),
    .pixel_x_i (pix_i.pixel_x),
    .pixel_y_i (pix_i.pixel_y),
    .coef_i    (coef),
    .valid_o   (fr_valid),
    .item_o    (item)
  );

  prd_norm #(
    .FRAC_BITS (FRAC_BITS)
  ) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .item_i  (item),
    .valid_o (out_valid),
    .dir_o   (dir)
  );

  assign dir_o.valid = out_valid;
  assign dir_o.dir_x = dir[0];
  assign dir_o.dir_y = dir[1];
  assign dir_o.dir_z = dir[2];

`ifndef SYNTHESIS
  a_no_item_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |-> !busy)
    else $error("item taken during basis rebuild");

  a_cfg_starts_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy)
    else $error("config write did not start basis rebuild");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dir_o.valid && !dir_o.ready) |-> !pix_i.ready)
    else $error("input open while output stalled");
`endif

endmodule

// File: bench/prd_ray_checker.sv
// Ray direction checker: tracks the camera registers, predicts each ray and compares.
`timescale 1ns / 1ps
module prd_ray_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [prd_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [prd_pkg::CFG_W-1:0] cfg_data_i,
  prd_pix_if                        pix,
  prd_dir_if                        dir,
  output int                        fails_o,
  output int                        pending_o,
  output int                        rays_o
);

  localparam int FRAC = 14;

  typedef longint vec3_t [3];
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } ray_t;

  logic [47:0]               fwd_q, up_q;
  logic [prd_pkg::TAN_W-1:0] tan_q;
  logic [prd_pkg::VP_W-1:0]  vw_q, vh_q;
  ray_t                      ray_q[$];

  function automatic longint round_shr(longint a, int k);
    longint unsigned m;
    if (k <= 0) return a;
    m = (a < 0) ? longint'(-a) : a;
    m = (m + (64'd1 << (k - 1))) >> k;
    return (a < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned s);
    longint unsigned res, b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s   = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic vec3_t unit_vec(vec3_t v, int ob);
    vec3_t o;
    longint unsigned s, n, m;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m = (v[i] < 0) ? longint'(-v[i]) : v[i];
      s = s + m * m;
    end
    n = floor_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      if (n == 0) begin
        o[i] = 0;
      end else begin
        m    = (v[i] < 0) ? longint'(-v[i]) : v[i];
        m    = ((m << ob) + n / 2) / n;
        o[i] = (v[i] < 0) ? -longint'(m) : longint'(m);
      end
    end
    return o;
  endfunction

  function automatic vec3_t cross_q30(vec3_t a, vec3_t b);
    vec3_t o;
    o[0] = round_shr(a[1] * b[2] - a[2] * b[1], 30);
    o[1] = round_shr(a[2] * b[0] - a[0] * b[2], 30);
    o[2] = round_shr(a[0] * b[1] - a[1] * b[0], 30);
    return o;
  endfunction

  function automatic vec3_t split_vec(logic [47:0] p);
    vec3_t o;
    for (int i = 0; i < 3; i++) o[i] = longint'($signed(p[16*i +: 16]));
    return o;
  endfunction

  function automatic ray_t predict_ray(logic [11:0] px, logic [11:0] py);
    vec3_t  gz, un, rt, wv, d, u;
    longint tu, tv, hs, t, wd, ht, c;
    longint unsigned mx, m;
    int     s;
    ray_t   r;
    t   = tan_q;
    wd  = vw_q;
    ht  = vh_q;
    gz  = unit_vec(split_vec(fwd_q), 30);
    un  = unit_vec(split_vec(up_q), 30);
    rt  = unit_vec(cross_q30(gz, un), 30);
    wv  = cross_q30(rt, gz);
    tu  = t * (2 * longint'(px) + 1 - wd);
    tv  = t * (2 * longint'(py) + 1 - ht);
    hs  = ht * 65536;
    mx  = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = round_shr(rt[i], 10) * tu + round_shr(wv[i], 10) * tv
           + round_shr(gz[i], 10) * hs;
      m = (d[i] < 0) ? longint'(-d[i]) : d[i];
      if (m > mx) mx = m;
    end
    s = 0;
    while ((mx >> s) >= (64'd1 << 30)) s++;
    for (int i = 0; i < 3; i++) d[i] = round_shr(d[i], s);
    u = unit_vec(d, FRAC);
    for (int i = 0; i < 3; i++) begin
      c = u[i];
      if (c > 32767) c = 32767;
      if (c < -32768) c = -32768;
      u[i] = c;
    end
    r.x = u[0][15:0];
    r.y = u[1][15:0];
    r.z = u[2][15:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= '0;
      up_q  <= '0;
      tan_q <= prd_pkg::TAN_RST;
      vw_q  <= prd_pkg::VW_RST;
      vh_q  <= prd_pkg::VH_RST;
    end else if (cfg_we_i) begin
      case (prd_pkg::reg_idx_e'(cfg_idx_i))
        prd_pkg::REG_FWD: fwd_q <= cfg_data_i[47:0];
        prd_pkg::REG_UP:  up_q  <= cfg_data_i[47:0];
        prd_pkg::REG_TAN: tan_q <= cfg_data_i[prd_pkg::TAN_W-1:0];
        prd_pkg::REG_VW:  vw_q  <= cfg_data_i[prd_pkg::VP_W-1:0];
        prd_pkg::REG_VH:  vh_q  <= cfg_data_i[prd_pkg::VP_W-1:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    ray_t e;
    if (!rst_ni) begin
      fails_o = 0;
      rays_o  = 0;
    end else begin
      if (dir.valid && dir.ready) begin
        rays_o++;
        if (ray_q.size() == 0) begin
          $error("ray with no pending pixel item");
          fails_o++;
        end else begin
          e = ray_q.pop_front();
          if (dir.dir_x !== e.x) begin
            $error("dir_x: expected %0d, got %0d", e.x, dir.dir_x);
            fails_o++;
          end
          if (dir.dir_y !== e.y) begin
            $error("dir_y: expected %0d, got %0d", e.y, dir.dir_y);
            fails_o++;
          end
          if (dir.dir_z !== e.z) begin
            $error("dir_z: expected %0d, got %0d", e.z, dir.dir_z);
            fails_o++;
          end
        end
      end
      if (pix.valid && pix.ready) ray_q.push_back(predict_ray(pix.pixel_x, pix.pixel_y));
    end
    pending_o = ray_q.size();
  end

endmodule

// File: bench/tb_top.sv
// Testbench top: camera settings, pixel stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam int LIMIT = 900000;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [prd_pkg::IDX_W-1:0] cfg_idx_i = '0;
  logic [prd_pkg::CFG_W-1:0] cfg_data_i = '0;
  int                        fails, pending, rays, cycles, settings, items;
  int                        stall_left;
  bit                        calm, noisy, long_req, long_done;
  int unsigned               cur_w, cur_h;

  prd_pix_if #(.COORD_BITS(12)) pix ();
  prd_dir_if                    dir ();

  always #5 clk_i = ~clk_i;

  pinhole_ray_direction dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .pix_i(pix), .dir_o(dir)
  );

  prd_ray_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .pix(pix), .dir(dir),
    .fails_o(fails), .pending_o(pending), .rays_o(rays)
  );

  // receiver: random hold-off bursts, one long stall on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir.ready  <= 1'b0;
      stall_left <= 0;
      long_done  <= 1'b0;
    end else if (stall_left != 0) begin
      dir.ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (long_req && !long_done) begin
      dir.ready  <= 1'b0;
      stall_left <= 400;
      long_done  <= 1'b1;
    end else if (!calm && noisy && $urandom_range(0, 7) == 0) begin
      dir.ready  <= 1'b0;
      stall_left <= $urandom_range(0, 16);
    end else begin
      dir.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_pix(logic [11:0] px, logic [11:0] py);
    int gap;
    if (!calm && noisy && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid   <= 1'b1;
    pix.pixel_x <= px;
    pix.pixel_y <= py;
    @(negedge clk_i);
    while (!pix.ready) @(negedge clk_i);
    @(posedge clk_i);
    items++;
  endtask

  task automatic wait_idle();
    pix.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(prd_pkg::reg_idx_e idx, logic [prd_pkg::CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic set_camera(logic [47:0] fwd, logic [47:0] up, logic [23:0] tn,
                            int unsigned w, int unsigned h);
    write_reg(prd_pkg::REG_FWD, fwd);
    write_reg(prd_pkg::REG_UP, up);
    write_reg(prd_pkg::REG_TAN, 48'(tn));
    write_reg(prd_pkg::REG_VW, 48'(w));
    write_reg(prd_pkg::REG_VH, 48'(h));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cur_w = w;
    cur_h = h;
    settings++;
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  function automatic logic [23:0] rand_tan();
    case ($urandom_range(0, 5))
      0: return 24'd0;
      1: return 24'hffffff;
      2: return 24'($urandom_range(0, 24'hffffff));
      default: return 24'($urandom_range(16'h2000, 24'h3ffff));
    endcase
  endfunction

  function automatic int unsigned rand_size();
    case ($urandom_range(0, 7))
      0: return 4096;
      1: return 1;
      2: return $urandom_range(0, 1);
      default: return $urandom_range(2, 4096);
    endcase
  endfunction

  initial begin
    logic [11:0] px, py;
    pix.valid   = 1'b0;
    pix.pixel_x = '0;
    pix.pixel_y = '0;
    items = 0; settings = 0;
    calm = 1'b0; noisy = 1'b1; long_req = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset: zero forward, every ray is zero
    send_pix(12'd0, 12'd0);
    send_pix(12'hfff, 12'hfff);
    send_pix(12'd1, 12'd2000);
    wait_idle();

    set_camera({16'hc000, 16'h0000, 16'h0000}, {16'h0000, 16'h4000, 16'h0000},
               24'd65536, 640, 480);
    send_pix(12'd0, 12'd0);
    send_pix(12'd639, 12'd479);
    send_pix(12'hfff, 12'd0);
    send_pix(12'd0, 12'hfff);
    send_pix(12'hfff, 12'hfff);
    send_pix(12'd320, 12'd240);
    send_pix(12'haaa, 12'h555);
    send_pix(12'h555, 12'haaa);
    wait_idle();
    // forward parallel to up
    set_camera({16'h0000, 16'h4000, 16'h0000}, {16'h0000, 16'he000, 16'h0000},
               24'd65536, 640, 480);
    send_pix(12'd5, 12'd7);
    send_pix(12'd600, 12'd400);
    wait_idle();
    // zero tangent, then the largest tangent, both at full size
    set_camera({16'h1234, 16'hf00d, 16'h0bad}, {16'h0100, 16'h7fff, 16'h0000},
               24'd0, 4096, 4096);
    send_pix(12'd0, 12'd0);
    send_pix(12'hfff, 12'd17);
    wait_idle();
    set_camera({16'h1234, 16'hf00d, 16'h0bad}, {16'h0100, 16'h7fff, 16'h0000},
               24'hffffff, 4096, 4096);
    send_pix(12'd0, 12'd0);
    send_pix(12'hfff, 12'hfff);
    send_pix(12'd2048, 12'd2047);
    wait_idle();
    // zero height, then zero width
    set_camera({16'h4000, 16'h0000, 16'h0000}, {16'h0000, 16'h4000, 16'h0000},
               24'd65536, 100, 0);
    send_pix(12'd10, 12'd10);
    send_pix(12'd99, 12'd0);
    wait_idle();
    set_camera({16'h4000, 16'h0000, 16'h0000}, {16'h0000, 16'h4000, 16'h0000},
               24'd65536, 0, 100);
    send_pix(12'd10, 12'd10);
    send_pix(12'd0, 12'd99);
    wait_idle();
    set_camera({16'h8000, 16'h8000, 16'h8000}, {16'h8000, 16'h0000, 16'h7fff},
               24'd32768, 1, 1);
    send_pix(12'd0, 12'd0);
    send_pix(12'd1, 12'd1);
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      set_camera({rand_comp(), rand_comp(), rand_comp()},
                 {rand_comp(), rand_comp(), rand_comp()},
                 rand_tan(), rand_size(), rand_size());
      noisy    = (ph % 3) != 2;
      long_req = (ph == 3);
      calm     = (ph == 9);
      for (int n = 0; n < 113; n++) begin
        if ($urandom_range(0, 3) == 0 || cur_w == 0 || cur_h == 0) begin
          px = 12'($urandom_range(0, 4095));
          py = 12'($urandom_range(0, 4095));
        end else begin
          px = 12'($urandom_range(0, cur_w - 1));
          py = 12'($urandom_range(0, cur_h - 1));
        end
        send_pix(px, py);
      end
      wait_idle();
    end

    $display("Sent %0d pixel items and checked %0d rays over %0d camera settings,",
             items, rays, settings);
    $display("with random hold-offs on both sides and one long output stall.");
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
